// ===== rtl/fmm_pkg.sv =====
// ----------------------------------------------------------------------------
// fmm_pkg
// shared types and codes of the flight mode manager: modes, reasons,
// register indexes, item, configuration and state structs
// ----------------------------------------------------------------------------
`default_nettype none

package fmm_pkg;

  // apb address width: seven 32-bit registers at byte offsets 0..24
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_DETUMBLE = 3'd1,
    MODE_ACQUIRE  = 3'd2,
    MODE_POINT    = 3'd3,
    MODE_SAFE     = 3'd4
  } mode_e;

  // transition reasons
  localparam logic [2:0] WHY_SENSORS_READY = 3'd0;
  localparam logic [2:0] WHY_SETTLED       = 3'd1;
  localparam logic [2:0] WHY_NO_SUN        = 3'd2;
  localparam logic [2:0] WHY_ATTITUDE_BAD  = 3'd3;
  localparam logic [2:0] WHY_ACQUIRED      = 3'd4;
  localparam logic [2:0] WHY_POINTING_LOST = 3'd5;
  localparam logic [2:0] WHY_RECOVERED     = 3'd6;

  // register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_BOOT_DWELL        = 3'd0;
  localparam logic [2:0] REG_POST_SETTLE_DWELL = 3'd1;
  localparam logic [2:0] REG_ACQUIRE_DWELL     = 3'd2;
  localparam logic [2:0] REG_LOSS_DWELL        = 3'd3;
  localparam logic [2:0] REG_SAFE_ENTRY_DWELL  = 3'd4;
  localparam logic [2:0] REG_SAFE_EXIT_DWELL   = 3'd5;
  localparam logic [2:0] REG_LOSS_THRESHOLD    = 3'd6;

  typedef struct packed {
    logic [31:0] sample_time;
    logic        control_running;
    logic        rate_settled;
    logic        in_shadow;
    logic        sun_seen;
    logic        attitude_ok;
    logic        target_locked;
    logic [15:0] pointing_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        changed;
    logic [2:0]  previous_mode;
    logic [2:0]  why;
    logic [31:0] mode_age;
    logic [31:0] pending_age;
    logic        torquers_on;
    logic        time_error;
  } out_item_t;

  typedef struct packed {
    logic [31:0] boot_dwell;
    logic [31:0] post_settle_dwell;
    logic [31:0] acquire_dwell;
    logic [31:0] loss_dwell;
    logic [31:0] safe_entry_dwell;
    logic [31:0] safe_exit_dwell;
    logic [15:0] loss_threshold;
  } cfg_t;

  // control part of the mode machine state (time stamps travel apart)
  typedef struct packed {
    mode_e      mode;
    logic       pending_valid;
    mode_e      pending_target;
    logic [2:0] pending_cause;
    logic       time_seen;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fmm_cfg.sv =====
// ----------------------------------------------------------------------------
// fmm_cfg
// apb register file holding the dwell times and the pointing loss threshold
// ----------------------------------------------------------------------------
`default_nettype none

module fmm_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fmm_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [fmm_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [fmm_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  output fmm_pkg::cfg_t                          cfg
);
  import fmm_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_BITS-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BOOT_DWELL:        cfg_nxt.boot_dwell        = pwdata;
        REG_POST_SETTLE_DWELL: cfg_nxt.post_settle_dwell = pwdata;
        REG_ACQUIRE_DWELL:     cfg_nxt.acquire_dwell     = pwdata;
        REG_LOSS_DWELL:        cfg_nxt.loss_dwell        = pwdata;
        REG_SAFE_ENTRY_DWELL:  cfg_nxt.safe_entry_dwell  = pwdata;
        REG_SAFE_EXIT_DWELL:   cfg_nxt.safe_exit_dwell   = pwdata;
        REG_LOSS_THRESHOLD:    cfg_nxt.loss_threshold    = pwdata[15:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BOOT_DWELL:        prdata = cfg_r.boot_dwell;
      REG_POST_SETTLE_DWELL: prdata = cfg_r.post_settle_dwell;
      REG_ACQUIRE_DWELL:     prdata = cfg_r.acquire_dwell;
      REG_LOSS_DWELL:        prdata = cfg_r.loss_dwell;
      REG_SAFE_ENTRY_DWELL:  prdata = cfg_r.safe_entry_dwell;
      REG_SAFE_EXIT_DWELL:   prdata = cfg_r.safe_exit_dwell;
      REG_LOSS_THRESHOLD:    prdata = {16'd0, cfg_r.loss_threshold};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/fmm_step.sv =====
// ----------------------------------------------------------------------------
// fmm_step
// next state and result of the mode machine for one status sample
// ----------------------------------------------------------------------------
`default_nettype none

module fmm_step #(
  parameter int TIME_BITS = 32
) (
  input  wire fmm_pkg::in_item_t    item,
  input  wire fmm_pkg::cfg_t        cfg,
  input  wire fmm_pkg::ctrl_t       ctrl,
  input  wire logic [TIME_BITS-1:0] pending_since,
  input  wire logic [TIME_BITS-1:0] mode_since,
  input  wire logic [TIME_BITS-1:0] last_time,
  output fmm_pkg::ctrl_t            ctrl_nxt,
  output logic      [TIME_BITS-1:0] pending_since_nxt,
  output logic      [TIME_BITS-1:0] mode_since_nxt,
  output logic      [TIME_BITS-1:0] last_time_nxt,
  output fmm_pkg::out_item_t        result
);
  import fmm_pkg::*;

  // low 32 bits of a time value, zero filled when time is narrower
  function automatic logic [31:0] low32(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS+31:0] w;
    w = {32'd0, v};
    return w[31:0];
  endfunction

  logic [TIME_BITS+31:0] t_wide;
  logic [TIME_BITS-1:0]  t;
  logic                  sun;
  logic                  back;
  logic                  req;
  mode_e                 tgt;
  logic [2:0]            cause;
  logic [31:0]           dwell;
  logic                  new_pend;
  logic [TIME_BITS-1:0]  since_eff;
  logic [TIME_BITS-1:0]  page;
  logic                  take;
  logic                  changed;

  assign t_wide = {{TIME_BITS{1'b0}}, item.sample_time};
  assign t      = t_wide[TIME_BITS-1:0];
  assign sun    = item.sun_seen & ~item.in_shadow;
  assign back   = ctrl.time_seen && (t < last_time);

  // request decode per mode
  always_comb begin
    req   = 1'b0;
    tgt   = MODE_BOOT;
    cause = WHY_SENSORS_READY;
    dwell = '0;
    unique case (ctrl.mode)
      MODE_BOOT: begin
        if (item.control_running) begin
          req   = 1'b1;
          tgt   = MODE_DETUMBLE;
          cause = WHY_SENSORS_READY;
          dwell = cfg.boot_dwell;
        end
      end
      MODE_DETUMBLE: begin
        if (item.rate_settled) begin
          req   = 1'b1;
          dwell = cfg.post_settle_dwell;
          if (!sun) begin
            tgt   = MODE_SAFE;
            cause = WHY_NO_SUN;
          end else if (!item.attitude_ok) begin
            tgt   = MODE_SAFE;
            cause = WHY_ATTITUDE_BAD;
          end else begin
            tgt   = MODE_ACQUIRE;
            cause = WHY_SETTLED;
          end
        end
      end
      MODE_ACQUIRE, MODE_POINT: begin
        if (!sun) begin
          req   = 1'b1;
          tgt   = MODE_SAFE;
          cause = WHY_NO_SUN;
          dwell = cfg.safe_entry_dwell;
        end else if (!item.attitude_ok) begin
          req   = 1'b1;
          tgt   = MODE_SAFE;
          cause = WHY_ATTITUDE_BAD;
          dwell = cfg.safe_entry_dwell;
        end else if (ctrl.mode == MODE_ACQUIRE && item.target_locked) begin
          req   = 1'b1;
          tgt   = MODE_POINT;
          cause = WHY_ACQUIRED;
          dwell = cfg.acquire_dwell;
        end else if (ctrl.mode == MODE_POINT &&
                     item.pointing_error >= cfg.loss_threshold) begin
          req   = 1'b1;
          tgt   = MODE_ACQUIRE;
          cause = WHY_POINTING_LOST;
          dwell = cfg.loss_dwell;
        end
      end
      default: begin
        // safe, and any unused code behaves as safe
        if (sun && item.attitude_ok) begin
          req   = 1'b1;
          tgt   = MODE_ACQUIRE;
          cause = WHY_RECOVERED;
          dwell = cfg.safe_exit_dwell;
        end
      end
    endcase
  end

  assign new_pend  = !ctrl.pending_valid || (ctrl.pending_target != tgt) ||
                     (ctrl.pending_cause != cause);
  assign since_eff = new_pend ? t : pending_since;
  assign page      = t - since_eff;
  assign take      = req && ({32'd0, page} >= {{TIME_BITS{1'b0}}, dwell});
  assign changed   = !back && take && (tgt != ctrl.mode);

  always_comb begin
    ctrl_nxt          = ctrl;
    pending_since_nxt = pending_since;
    mode_since_nxt    = mode_since;
    last_time_nxt     = last_time;
    if (!back) begin
      last_time_nxt      = t;
      ctrl_nxt.time_seen = 1'b1;
      if (req && !take) begin
        ctrl_nxt.pending_valid  = 1'b1;
        ctrl_nxt.pending_target = tgt;
        ctrl_nxt.pending_cause  = cause;
        pending_since_nxt       = since_eff;
      end else begin
        ctrl_nxt.pending_valid  = 1'b0;
        ctrl_nxt.pending_target = MODE_BOOT;
        ctrl_nxt.pending_cause  = WHY_SENSORS_READY;
        pending_since_nxt       = t;
      end
      if (changed) begin
        ctrl_nxt.mode  = tgt;
        mode_since_nxt = t;
      end
    end
  end

  always_comb begin
    result.mode          = ctrl_nxt.mode;
    result.changed       = changed;
    result.previous_mode = changed ? ctrl.mode : ctrl_nxt.mode;
    result.why           = changed ? cause : WHY_SENSORS_READY;
    result.torquers_on   = (ctrl_nxt.mode == MODE_DETUMBLE) && !item.rate_settled;
    result.time_error    = back;
    if (back) begin
      result.mode_age    = low32(last_time - mode_since);
      result.pending_age = ctrl.pending_valid ? low32(last_time - pending_since) : '0;
    end else begin
      result.mode_age    = low32(t - mode_since_nxt);
      result.pending_age = (req && !take) ? low32(page) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/flight_mode_manager.sv =====
// ----------------------------------------------------------------------------
// flight_mode_manager
// five-mode spacecraft mode machine with dwell-qualified transitions
// ----------------------------------------------------------------------------
// Takes one timestamped status sample per item and moves between boot,
// detumble, sun acquire, sun point and safe. A requested transition must
// persist for its dwell time (set over the apb port) before it is taken;
// a new target or reason restarts the dwell timer and a sample with no
// request clears it. Each item produces exactly one result item carrying
// the mode, the transition event, elapsed times and the magnetorquer
// enable. A sample whose time stamp is below the last accepted one is
// flagged with time_error and leaves the state untouched. Throughput is
// one item per clock unless out_ready stalls the output; an accepted
// item's result appears in the output register on the next cycle. The
// whole step is one pass of compare and subtract logic feeding the state
// and result registers, and the input stays ready while the output
// register is empty or being drained. Configuration writes take effect at
// once, so registers should be written only while no item is in flight.
`default_nettype none

module flight_mode_manager #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire fmm_pkg::in_item_t                 in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output fmm_pkg::out_item_t                     out_data,
  // apb configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fmm_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [fmm_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [fmm_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                   pready
);
  import fmm_pkg::*;

  cfg_t                 cfg;

  // mode machine state
  ctrl_t                ctrl_r;
  ctrl_t                ctrl_nxt;
  logic [TIME_BITS-1:0] pending_since_r;
  logic [TIME_BITS-1:0] pending_since_nxt;
  logic [TIME_BITS-1:0] mode_since_r;
  logic [TIME_BITS-1:0] mode_since_nxt;
  logic [TIME_BITS-1:0] last_time_r;
  logic [TIME_BITS-1:0] last_time_nxt;

  // result register
  out_item_t            result;
  out_item_t            out_data_r;
  logic                 out_valid_r;

  logic                 in_accept;

  // dwell and threshold registers
  fmm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // one step of the mode machine, purely combinational
  fmm_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item              (in_data),
    .cfg               (cfg),
    .ctrl              (ctrl_r),
    .pending_since     (pending_since_r),
    .mode_since        (mode_since_r),
    .last_time         (last_time_r),
    .ctrl_nxt          (ctrl_nxt),
    .pending_since_nxt (pending_since_nxt),
    .mode_since_nxt    (mode_since_nxt),
    .last_time_nxt     (last_time_nxt),
    .result            (result)
  );

  // take a new item whenever the result slot is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // state advances only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.mode           <= MODE_BOOT;
      ctrl_r.pending_valid  <= 1'b0;
      ctrl_r.pending_target <= MODE_BOOT;
      ctrl_r.pending_cause  <= WHY_SENSORS_READY;
      ctrl_r.time_seen      <= 1'b0;
      pending_since_r       <= '0;
      mode_since_r          <= '0;
      last_time_r           <= '0;
    end else if (in_accept) begin
      ctrl_r          <= ctrl_nxt;
      pending_since_r <= pending_since_nxt;
      mode_since_r    <= mode_since_nxt;
      last_time_r     <= last_time_nxt;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
